[hdl/sta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_pkg
// shared types, sizes and us-layout key tables for the scancode front end
// ----------------------------------------------------------------------------
package sta_pkg;

    localparam int BUFFER_DEPTH = 128;
    localparam int PTR_W        = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CHAR_W       = 7;

    typedef struct packed {
        logic       action;
        logic [7:0] scan_byte;
    } in_t;

    typedef struct packed {
        logic              empty_res;
        logic [CHAR_W-1:0] key_char;
    } out_t;

    // queued work for the back end: a character to store or a poll
    typedef struct packed {
        logic              is_poll;
        logic [CHAR_W-1:0] ch;
    } op_t;

    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] r;
        begin
            case (code)
                7'h01: r = 7'h1B;  7'h02: r = 7'h31;  7'h03: r = 7'h32;  7'h04: r = 7'h33;
                7'h05: r = 7'h34;  7'h06: r = 7'h35;  7'h07: r = 7'h36;  7'h08: r = 7'h37;
                7'h09: r = 7'h38;  7'h0A: r = 7'h39;  7'h0B: r = 7'h30;  7'h0C: r = 7'h2D;
                7'h0D: r = 7'h3D;  7'h0E: r = 7'h08;  7'h0F: r = 7'h09;
                7'h10: r = 7'h71;  7'h11: r = 7'h77;  7'h12: r = 7'h65;  7'h13: r = 7'h72;
                7'h14: r = 7'h74;  7'h15: r = 7'h79;  7'h16: r = 7'h75;  7'h17: r = 7'h69;
                7'h18: r = 7'h6F;  7'h19: r = 7'h70;  7'h1A: r = 7'h5B;  7'h1B: r = 7'h5D;
                7'h1C: r = 7'h0A;  7'h1E: r = 7'h61;  7'h1F: r = 7'h73;
                7'h20: r = 7'h64;  7'h21: r = 7'h66;  7'h22: r = 7'h67;  7'h23: r = 7'h68;
                7'h24: r = 7'h6A;  7'h25: r = 7'h6B;  7'h26: r = 7'h6C;  7'h27: r = 7'h3B;
                7'h28: r = 7'h27;  7'h29: r = 7'h60;  7'h2B: r = 7'h5C;  7'h2C: r = 7'h7A;
                7'h2D: r = 7'h78;  7'h2E: r = 7'h63;  7'h2F: r = 7'h76;
                7'h30: r = 7'h62;  7'h31: r = 7'h6E;  7'h32: r = 7'h6D;  7'h33: r = 7'h2C;
                7'h34: r = 7'h2E;  7'h35: r = 7'h2F;  7'h37: r = 7'h2A;  7'h39: r = 7'h20;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] code);
        logic [CHAR_W-1:0] r;
        begin
            case (code)
                7'h01: r = 7'h1B;  7'h02: r = 7'h21;  7'h03: r = 7'h40;  7'h04: r = 7'h23;
                7'h05: r = 7'h24;  7'h06: r = 7'h25;  7'h07: r = 7'h5E;  7'h08: r = 7'h26;
                7'h09: r = 7'h2A;  7'h0A: r = 7'h28;  7'h0B: r = 7'h29;  7'h0C: r = 7'h5F;
                7'h0D: r = 7'h2B;  7'h0E: r = 7'h08;  7'h0F: r = 7'h09;
                7'h10: r = 7'h51;  7'h11: r = 7'h57;  7'h12: r = 7'h45;  7'h13: r = 7'h52;
                7'h14: r = 7'h54;  7'h15: r = 7'h59;  7'h16: r = 7'h55;  7'h17: r = 7'h49;
                7'h18: r = 7'h4F;  7'h19: r = 7'h50;  7'h1A: r = 7'h7B;  7'h1B: r = 7'h7D;
                7'h1C: r = 7'h0A;  7'h1E: r = 7'h41;  7'h1F: r = 7'h53;
                7'h20: r = 7'h44;  7'h21: r = 7'h46;  7'h22: r = 7'h47;  7'h23: r = 7'h48;
                7'h24: r = 7'h4A;  7'h25: r = 7'h4B;  7'h26: r = 7'h4C;  7'h27: r = 7'h3A;
                7'h28: r = 7'h22;  7'h29: r = 7'h7E;  7'h2B: r = 7'h7C;  7'h2C: r = 7'h5A;
                7'h2D: r = 7'h58;  7'h2E: r = 7'h43;  7'h2F: r = 7'h56;
                7'h30: r = 7'h42;  7'h31: r = 7'h4E;  7'h32: r = 7'h4D;  7'h33: r = 7'h3C;
                7'h34: r = 7'h3E;  7'h35: r = 7'h3F;  7'h37: r = 7'h2A;  7'h39: r = 7'h20;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

[hdl/scancode_to_ascii_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_core
// scancode set 1 to us-layout ascii decoder with a polled character buffer
// ----------------------------------------------------------------------------
// Each cmd beat is either a scancode byte (action = 0) or a poll (action = 1).
// Scancode bytes update shift, ctrl, caps lock and the e0 prefix state; key
// presses that map to a character are stored in a ring buffer that holds up
// to BUFFER_DEPTH-1 characters, and a character arriving at a full buffer is
// dropped. Only polls give a rsp beat: the oldest character, or empty_res = 1
// with key_char = 0 when nothing is buffered. The block takes one cmd beat
// per clock; a poll's rsp beat passes through the op queue register and the
// output register before it comes out. The ring buffer ram has one write
// and one read port, and the back end serves one queued op per cycle, so a
// stalled rsp side only holds the input once the two-entry op queue has
// filled. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  sta_pkg::in_t  cmd,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sta_pkg::out_t rsp
);
    import sta_pkg::*;

    // decoder to queue
    logic q_space;
    logic push;
    op_t  push_op;

    // queue to ring buffer
    logic q_valid;
    op_t  q_op;
    logic q_pop;

    // front: modifier tracking and key table lookup
    sta_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .q_space   (q_space),
        .push      (push),
        .push_op   (push_op)
    );

    // short queue so each side can stall on its own
    sta_opq u_opq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .space   (q_space),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (q_pop)
    );

    // back: character store, polls, output register
    sta_ring u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

[hdl/sta_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/sta_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_decode
// front end: tracks modifiers and turns scancode bytes into character ops
// ----------------------------------------------------------------------------
module sta_decode (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  sta_pkg::in_t  cmd,
    input  logic          q_space,
    output logic          push,
    output sta_pkg::op_t  push_op
);
    import sta_pkg::*;

    localparam logic [7:0]        SC_PREFIX  = 8'hE0;
    localparam logic [6:0]        SC_SHIFT_L = 7'h2A;
    localparam logic [6:0]        SC_SHIFT_R = 7'h36;
    localparam logic [6:0]        SC_CTRL    = 7'h1D;
    localparam logic [6:0]        SC_CAPS    = 7'h3A;
    localparam logic [CHAR_W-1:0] CTRL_MASK  = 7'h1F;
    localparam logic [CHAR_W-1:0] CASE_DELTA = 7'h20;
    localparam logic [CHAR_W-1:0] LOW_A      = 7'h61;
    localparam logic [CHAR_W-1:0] LOW_Z      = 7'h7A;
    localparam logic [CHAR_W-1:0] UP_A       = 7'h41;
    localparam logic [CHAR_W-1:0] UP_Z       = 7'h5A;

    logic shift_reg, shift_next;
    logic ctrl_reg,  ctrl_next;
    logic caps_reg,  caps_next;
    logic pfx_reg,   pfx_next;

    logic              accept;
    logic              rel;
    logic [6:0]        code;
    logic [CHAR_W-1:0] raw_ch;
    logic [CHAR_W-1:0] case_ch;
    logic [CHAR_W-1:0] fin_ch;
    logic              emit;

    assign cmd_ready = q_space;
    assign accept    = cmd_valid && cmd_ready;
    assign rel       = cmd.scan_byte[7];
    assign code      = cmd.scan_byte[6:0];

    // table lookup, then caps and ctrl adjustment
    always_comb
    begin
        raw_ch = shift_reg ? shift_char(code) : plain_char(code);
        if (caps_reg && !shift_reg && raw_ch >= LOW_A && raw_ch <= LOW_Z)
        begin
            case_ch = raw_ch - CASE_DELTA;
        end
        else if (caps_reg && shift_reg && raw_ch >= UP_A && raw_ch <= UP_Z)
        begin
            case_ch = raw_ch + CASE_DELTA;
        end
        else
        begin
            case_ch = raw_ch;
        end
        if (ctrl_reg && case_ch >= LOW_A && case_ch <= LOW_Z)
        begin
            fin_ch = case_ch & CTRL_MASK;
        end
        else
        begin
            fin_ch = case_ch;
        end
    end

    always_comb
    begin
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        caps_next  = caps_reg;
        pfx_next   = pfx_reg;
        emit       = 1'b0;
        if (cmd.action)
        begin
            emit = 1'b1;
        end
        else if (cmd.scan_byte == SC_PREFIX)
        begin
            pfx_next = 1'b1;
        end
        else if (pfx_reg)
        begin
            pfx_next = 1'b0;
            if (code == SC_CTRL)
            begin
                ctrl_next = !rel;
            end
        end
        else if (code == SC_SHIFT_L || code == SC_SHIFT_R)
        begin
            shift_next = !rel;
        end
        else if (code == SC_CTRL)
        begin
            ctrl_next = !rel;
        end
        else if (code == SC_CAPS)
        begin
            if (!rel)
            begin
                caps_next = !caps_reg;
            end
        end
        else if (!rel && raw_ch != '0)
        begin
            emit = 1'b1;
        end
    end

    assign push            = accept && emit;
    assign push_op.is_poll = cmd.action;
    assign push_op.ch      = fin_ch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            ctrl_reg  <= 1'b0;
            caps_reg  <= 1'b0;
            pfx_reg   <= 1'b0;
        end
        else if (accept)
        begin
            shift_reg <= shift_next;
            ctrl_reg  <= ctrl_next;
            caps_reg  <= caps_next;
            pfx_reg   <= pfx_next;
        end
    end

endmodule

[hdl/sta_opq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_opq
// two-entry op queue between the decoder and the ring buffer
// ----------------------------------------------------------------------------
module sta_opq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sta_pkg::op_t  push_op,
    output logic          space,
    output logic          q_valid,
    output sta_pkg::op_t  q_op,
    input  logic          pop
);
    import sta_pkg::*;

    op_t        slot_reg [2];
    logic       head_reg, head_next;
    logic [1:0] count_reg, count_next;
    logic       tail;

    assign space   = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = slot_reg[head_reg];
    assign tail    = head_reg ^ count_reg[0];

    always_comb
    begin
        head_next  = pop ? !head_reg : head_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail] <= push_op;
        end
    end

endmodule

[hdl/sta_ring.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sta_ring
// back end: character ring buffer in ram, serves polls into an output register
// ----------------------------------------------------------------------------
module sta_ring (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  sta_pkg::op_t  q_op,
    output logic          q_pop,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output sta_pkg::out_t rsp
);
    import sta_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]  wr_inc, rd_inc;
    logic              rsp_valid_reg, rsp_valid_next;
    out_t              rsp_reg;
    logic              byp_reg, byp_next;
    logic [CHAR_W-1:0] byp_data_reg;
    logic [CHAR_W-1:0] ram_rdata;
    logic [CHAR_W-1:0] head_ch;
    logic              empty, full;
    logic              take_poll, take_write;
    logic              wr_en, rd_adv;

    assign wr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
    assign empty  = (wr_ptr_reg == rd_ptr_reg);
    assign full   = (wr_inc == rd_ptr_reg);

    assign take_poll  = q_valid && q_op.is_poll && (!rsp_valid_reg || rsp_ready);
    assign take_write = q_valid && !q_op.is_poll;
    assign q_pop      = take_poll || take_write;

    assign wr_en  = take_write && !full;
    assign rd_adv = take_poll && !empty;

    assign wr_ptr_next = wr_en ? wr_inc : wr_ptr_reg;
    assign rd_ptr_next = rd_adv ? rd_inc : rd_ptr_reg;

    // ram read tracks the head; a write into the head slot is forwarded
    assign byp_next = wr_en && (wr_ptr_reg == rd_ptr_next);
    assign head_ch  = byp_reg ? byp_data_reg : ram_rdata;

    assign rsp_valid_next = take_poll ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    sta_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_ptr_reg),
        .wdata (q_op.ch),
        .raddr (rd_ptr_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            rsp_valid_reg <= rsp_valid_next;
            byp_reg       <= byp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= q_op.ch;
        if (take_poll)
        begin
            rsp_reg.empty_res <= empty;
            rsp_reg.key_char  <= empty ? '0 : head_ch;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_ptr_reg <= PTR_LAST && rd_ptr_reg <= PTR_LAST)
        else $error("ring pointer out of range");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.empty_res |-> rsp_reg.key_char == '0)
        else $error("empty poll carries a character");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rd_adv |-> wr_ptr_reg != rd_ptr_reg)
        else $error("read pointer advanced on an empty buffer");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> wr_ptr_reg != rd_ptr_reg)
        else $error("write pointer overran the read pointer");
`endif

endmodule

[dv/tb_scancode_to_ascii_fifo_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scancode_to_ascii_fifo_core
// self-checking bench for the scancode set 1 decoder and its character buffer
// ----------------------------------------------------------------------------
// A queue of cmd beats is built up front: a directed opening that walks the
// modifiers, caps lock, the e0 prefix, unmapped codes and empty polls, then
// random typing, poll bursts, prefix sequences, noise and one burst that
// overfills the buffer. A clocked driver plays the queue out with random
// gaps, and a clocked monitor keeps a software copy of the decoder state and
// buffer, predicts every poll reply and checks each rsp beat against it.
// ----------------------------------------------------------------------------
module tb_scancode_to_ascii_fifo_core;

    import sta_pkg::*;

    // cmd action codes
    localparam logic ACT_SCAN = 1'b0;
    localparam logic ACT_POLL = 1'b1;

    // scancode set 1 codes with special meaning
    localparam logic [7:0] SC_PREFIX  = 8'hE0;
    localparam logic [6:0] SC_SHIFT_L = 7'h2A;
    localparam logic [6:0] SC_SHIFT_R = 7'h36;
    localparam logic [6:0] SC_CTRL    = 7'h1D;
    localparam logic [6:0] SC_CAPS    = 7'h3A;
    localparam logic [7:0] REL_BIT    = 8'h80;

    // ascii bounds and masks for the case and ctrl rules
    localparam logic [6:0] CH_LOWER_A = 7'h61;
    localparam logic [6:0] CH_LOWER_Z = 7'h7A;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [6:0] CH_UPPER_Z = 7'h5A;
    localparam logic [6:0] CASE_STEP  = 7'h20;
    localparam logic [6:0] CTRL_BITS  = 7'h1F;

    localparam int RAND_ITEMS   = 650;
    localparam int FILL_PRESSES = 140;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    logic  clk;
    logic  rst_n;
    logic  cmd_valid;
    logic  cmd_ready;
    in_t   cmd;
    logic  rsp_valid;
    logic  rsp_ready;
    out_t  rsp;

    // us layout, codes 0x00..0x3f; everything above maps to nothing
    logic [6:0] plain_keys [0:63] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    logic [6:0] shift_keys [0:63] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // stimulus and scoreboard storage
    in_t        pending_beats [$];
    out_t       expected_polls [$];
    logic [6:0] typed_chars [$];

    // mirrored decoder state
    logic m_shift;
    logic m_ctrl;
    logic m_caps;
    logic m_prefix;

    int   total_items;
    int   sent_cnt;
    int   poll_cnt;
    int   err_cnt;
    int   cycle_cnt;
    int   send_idle_pct;
    int   recv_idle_pct;
    out_t exp_rsp;

    scancode_to_ascii_fifo_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic push_scan(input logic [7:0] sb);
        in_t b;
        begin
            b.action    = ACT_SCAN;
            b.scan_byte = sb;
            pending_beats.push_back(b);
        end
    endtask

    // poll carries a random byte, the block should not look at it
    task automatic push_poll();
        in_t b;
        begin
            b.action    = ACT_POLL;
            b.scan_byte = 8'($urandom);
            pending_beats.push_back(b);
        end
    endtask

    // one key stroke with optional shift and ctrl around it
    task automatic push_keystroke();
        logic [7:0] shift_code;
        logic [7:0] key;
        logic       with_shift;
        logic       with_ctrl;
        begin
            with_shift = ($urandom_range(99) < 40);
            with_ctrl  = ($urandom_range(99) < 15);
            shift_code = $urandom_range(1) ? {1'b0, SC_SHIFT_L} : {1'b0, SC_SHIFT_R};
            key        = 8'($urandom_range(1, 8'h3F));
            if (with_shift)
                push_scan(shift_code);
            if (with_ctrl)
                push_scan({1'b0, SC_CTRL});
            push_scan(key);
            if ($urandom_range(99) < 80)
                push_scan(key | REL_BIT);
            if (with_ctrl)
                push_scan({1'b0, SC_CTRL} | REL_BIT);
            if (with_shift)
                push_scan(shift_code | REL_BIT);
        end
    endtask

    // e0 followed by right ctrl press/release or some other extended key
    task automatic push_extended();
        begin
            push_scan(SC_PREFIX);
            if ($urandom_range(99) < 15)
                push_scan(SC_PREFIX);
            case ($urandom_range(2))
                0: push_scan({1'b0, SC_CTRL});
                1: push_scan({1'b0, SC_CTRL} | REL_BIT);
                default: push_scan(8'($urandom));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // prediction: one accepted cmd beat against the mirrored state
    // ------------------------------------------------------------------
    task automatic predict_cmd(input in_t beat);
        logic [6:0] code;
        logic       rel;
        logic [6:0] ch;
        out_t       r;
        begin
            code = beat.scan_byte[6:0];
            rel  = beat.scan_byte[7];
            if (beat.action == ACT_POLL)
            begin
                if (typed_chars.size() == 0)
                begin
                    r.empty_res = 1'b1;
                    r.key_char  = '0;
                end
                else
                begin
                    r.empty_res = 1'b0;
                    r.key_char  = typed_chars.pop_front();
                end
                expected_polls.push_back(r);
            end
            else if (beat.scan_byte == SC_PREFIX)
                m_prefix = 1'b1;
            else if (m_prefix)
            begin
                // byte after e0 only matters when it is the ctrl code
                m_prefix = 1'b0;
                if (code == SC_CTRL)
                    m_ctrl = !rel;
            end
            else if (code == SC_SHIFT_L || code == SC_SHIFT_R)
                m_shift = !rel;
            else if (code == SC_CTRL)
                m_ctrl = !rel;
            else if (code == SC_CAPS)
            begin
                if (!rel)
                    m_caps = !m_caps;
            end
            else if (!rel)
            begin
                if (code[6])
                    ch = '0;
                else
                    ch = m_shift ? shift_keys[code[5:0]] : plain_keys[code[5:0]];
                if (ch != '0)
                begin
                    if (m_caps && !m_shift && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                        ch = ch - CASE_STEP;
                    else if (m_caps && m_shift && ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
                        ch = ch + CASE_STEP;
                    if (m_ctrl && ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
                        ch = ch & CTRL_BITS;
                    // buffer keeps one slot free, the overflow char is lost
                    if (typed_chars.size() < BUFFER_DEPTH - 1)
                        typed_chars.push_back(ch);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: plays pending_beats out on the cmd channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                sent_cnt = sent_cnt + 1;
                // idle profile follows progress through the stimulus
                if (sent_cnt * 3 >= total_items * 2)
                begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
                else if (sent_cnt * 3 >= total_items)
                begin
                    send_idle_pct <= 45;
                    recv_idle_pct <= 12;
                end
            end
            // a held beat is only replaced once it has been taken
            if (!cmd_valid || cmd_ready)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_beats.pop_front();
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // rsp side back-pressure
    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // monitor: rsp checked first so a same-edge reply cannot match its own cmd
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_polls.size() == 0)
                begin
                    if (err_cnt < MAX_REPORTS)
                        $display("unexpected rsp beat %0d: empty=%0b char=%02h",
                                 poll_cnt, rsp.empty_res, rsp.key_char);
                    err_cnt = err_cnt + 1;
                end
                else
                begin
                    exp_rsp = expected_polls.pop_front();
                    if (rsp.empty_res !== exp_rsp.empty_res ||
                        rsp.key_char !== exp_rsp.key_char)
                    begin
                        if (err_cnt < MAX_REPORTS)
                            $display("mismatch on rsp beat %0d: exp empty=%0b char=%02h, got empty=%0b char=%02h",
                                     poll_cnt, exp_rsp.empty_res, exp_rsp.key_char,
                                     rsp.empty_res, rsp.key_char);
                        err_cnt = err_cnt + 1;
                    end
                end
                poll_cnt = poll_cnt + 1;
            end
            if (cmd_valid && cmd_ready)
                predict_cmd(cmd);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        rsp_ready     = 1'b0;
        m_shift       = 1'b0;
        m_ctrl        = 1'b0;
        m_caps        = 1'b0;
        m_prefix      = 1'b0;
        sent_cnt      = 0;
        poll_cnt      = 0;
        err_cnt       = 0;
        cycle_cnt     = 0;
        send_idle_pct = 12;
        recv_idle_pct = 45;

        // directed opening
        push_poll();                               // poll on empty buffer
        push_scan(8'h1E);                          // plain 'a'
        push_scan(8'h9E);
        push_scan({1'b0, SC_SHIFT_L});             // shifted 'A'
        push_scan(8'h1E);
        push_scan({1'b0, SC_SHIFT_L} | REL_BIT);
        push_scan({1'b0, SC_SHIFT_R});             // right shift, '!'
        push_scan(8'h02);
        push_scan({1'b0, SC_SHIFT_R} | REL_BIT);
        push_scan({1'b0, SC_CAPS});                // caps on
        push_scan({1'b0, SC_CAPS} | REL_BIT);      // caps release, no toggle
        push_scan(8'h1E);                          // caps gives 'A'
        push_scan({1'b0, SC_SHIFT_L});             // caps with shift gives 'a'
        push_scan(8'h1E);
        push_scan({1'b0, SC_SHIFT_L} | REL_BIT);
        push_scan({1'b0, SC_CTRL});                // ctrl with caps on, 'C' stays
        push_scan(8'h2E);
        push_scan({1'b0, SC_CAPS});                // caps off, ctrl-c masks to 3
        push_scan(8'h2E);
        push_scan(SC_PREFIX);                      // double prefix, extended ctrl up
        push_scan(SC_PREFIX);
        push_scan({1'b0, SC_CTRL} | REL_BIT);
        push_scan(SC_PREFIX);                      // extended non-ctrl key ignored
        push_scan(8'h1E);
        push_scan(8'h00);                          // unmapped codes
        push_scan(8'h7F);
        push_scan(8'hFF);                          // release of nothing
        repeat (8) push_poll();

        // random part, one buffer overflow burst somewhere in the middle
        total_items = pending_beats.size() + RAND_ITEMS;
        while (pending_beats.size() < total_items)
        begin
            if (pending_beats.size() > 250 && pending_beats.size() < 300)
            begin
                repeat (FILL_PRESSES) push_scan(8'($urandom_range(8'h10, 8'h19)));
                repeat (FILL_PRESSES + 2) push_poll();
            end
            case ($urandom_range(9))
                0, 1, 2, 3: push_keystroke();
                4, 5, 6:    repeat ($urandom_range(1, 4)) push_poll();
                7:          push_extended();
                8:
                begin
                    push_scan({1'b0, SC_CAPS});
                    push_scan({1'b0, SC_CAPS} | REL_BIT);
                end
                default:    push_scan(8'($urandom));
            endcase
        end
        total_items = pending_beats.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the stimulus to drain and every poll to be answered
        while (pending_beats.size() != 0 || cmd_valid)
            @(posedge clk);
        while (expected_polls.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_polls.size() != 0)
            err_cnt = err_cnt + 1;
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
